// ----- rtl/tsv_pkg.sv -----
// Shared types, constants and a checksum fold helper for the TCP segment validator.
package tsv_pkg;

    localparam logic [2:0] VERDICT_ACCEPT    = 3'd0;
    localparam logic [2:0] VERDICT_SHORT     = 3'd1;
    localparam logic [2:0] VERDICT_BAD_HLEN  = 3'd2;
    localparam logic [2:0] VERDICT_BAD_FLAGS = 3'd3;
    localparam logic [2:0] VERDICT_BAD_CSUM  = 3'd4;
    localparam logic [2:0] VERDICT_OVERLONG  = 3'd5;

    localparam logic [16:0] COUNT_SAT     = 17'd65536;
    localparam logic [16:0] MIN_LEN       = 17'd20;
    localparam logic [16:0] OFFSET_BYTE   = 17'd12;
    localparam logic [16:0] FLAGS_BYTE    = 17'd13;
    localparam logic [3:0]  MIN_OFFSET    = 4'd5;
    localparam logic [17:0] PROTO_TCP     = 18'd6;
    localparam logic [7:0]  FL_FIN        = 8'h01;
    localparam logic [7:0]  FL_SYN        = 8'h02;
    localparam logic [15:0] CSUM_GOOD     = 16'hFFFF;
    localparam logic [15:0] LEN_SAT       = 16'hFFFF;

    typedef struct packed {
        logic [7:0]  seg_byte;
        logic        last_byte;
        logic [31:0] src_addr;
        logic [31:0] dst_addr;
    } tsv_in_t;

    typedef struct packed {
        logic [2:0]  verdict;
        logic [5:0]  header_bytes;
        logic [7:0]  flag_byte;
        logic [15:0] segment_bytes;
    } tsv_out_t;

    // registered input byte with the pseudo-header partial sum
    typedef struct packed {
        logic [7:0]  seg_byte;
        logic        last_byte;
        logic [18:0] ph_sum;
    } tsv_stage_t;

    // end-around carry fold of a 19-bit sum into 16 bits
    function automatic logic [15:0] fold19(input logic [18:0] x);
        logic [16:0] t;
        t = {1'b0, x[15:0]} + {14'd0, x[18:16]};
        return t[15:0] + {15'd0, t[16]};
    endfunction

endpackage

// ----- rtl/tsv_in_stage.sv -----
// Input register of the validator with pseudo-header address pre-sum.
module tsv_in_stage (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  tsv_pkg::tsv_in_t    s_data,
    input  logic                acc_ready,
    output logic                st_valid,
    output tsv_pkg::tsv_stage_t st_data
);
    import tsv_pkg::*;

    logic       valid_reg;
    logic       valid_next;
    tsv_stage_t data_reg;
    tsv_stage_t data_next;
    logic       load;

    assign s_ready = !valid_reg || acc_ready;
    assign load    = s_valid && s_ready;

    always_comb begin
        data_next.seg_byte  = s_data.seg_byte;
        data_next.last_byte = s_data.last_byte;
        data_next.ph_sum    = {3'b000, s_data.src_addr[31:16]}
                            + {3'b000, s_data.src_addr[15:0]}
                            + {3'b000, s_data.dst_addr[31:16]}
                            + {3'b000, s_data.dst_addr[15:0]}
                            + {1'b0, PROTO_TCP};
    end

    always_comb begin
        if (load) begin
            valid_next = 1'b1;
        end else if (acc_ready) begin
            valid_next = 1'b0;
        end else begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            data_reg <= data_next;
        end
    end

    assign st_valid = valid_reg;
    assign st_data  = data_reg;

endmodule

// ----- rtl/tsv_accum.sv -----
// Per-segment running state, verdict logic and result register.
module tsv_accum (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                st_valid,
    input  tsv_pkg::tsv_stage_t st_data,
    output logic                acc_ready,
    output logic                m_valid,
    input  logic                m_ready,
    output tsv_pkg::tsv_out_t   m_data
);
    import tsv_pkg::*;

    logic [16:0] count_reg;
    logic [16:0] count_next;
    logic [15:0] sum_reg;
    logic [15:0] sum_next;
    logic [7:0]  high_reg;
    logic [7:0]  high_next;
    logic        odd_reg;
    logic        odd_next;
    logic [3:0]  nib_reg;
    logic [3:0]  nib_next;
    logic [7:0]  flag_reg;
    logic [7:0]  flag_next;
    logic        m_valid_reg;
    logic        m_valid_next;
    tsv_out_t    m_data_reg;
    tsv_out_t    result;

    logic        fire;
    logic        fire_last;
    logic [3:0]  nib_upd;
    logic [7:0]  flag_upd;
    logic [15:0] sum_upd;
    logic [16:0] count_upd;
    logic [18:0] csum_total;
    logic [15:0] csum_fold;
    logic [5:0]  hdr_bytes;
    logic        flags_bad;

    assign acc_ready = !m_valid_reg || m_ready;
    assign fire      = st_valid && acc_ready;
    assign fire_last = fire && st_data.last_byte;

    always_comb begin
        nib_upd   = (count_reg == OFFSET_BYTE) ? st_data.seg_byte[7:4] : nib_reg;
        flag_upd  = (count_reg == FLAGS_BYTE) ? st_data.seg_byte : flag_reg;
        sum_upd   = odd_reg ? fold19({3'b000, sum_reg} + {3'b000, high_reg, st_data.seg_byte})
                            : sum_reg;
        count_upd = (count_reg < COUNT_SAT) ? count_reg + 17'd1 : count_reg;

        // odd_reg clear means this byte opens a word, padded with a zero low byte
        csum_total = {3'b000, sum_upd}
                   + (odd_reg ? 19'd0 : {3'b000, st_data.seg_byte, 8'h00})
                   + st_data.ph_sum
                   + {3'b000, count_upd[15:0]};
        csum_fold  = fold19(csum_total);

        hdr_bytes = {nib_upd, 2'b00};
        flags_bad = (((flag_upd & FL_SYN) != 8'h00) && ((flag_upd & FL_FIN) != 8'h00))
                 || (flag_upd == 8'h00);

        if (count_upd >= COUNT_SAT) begin
            result.verdict = VERDICT_OVERLONG;
        end else if (count_upd < MIN_LEN) begin
            result.verdict = VERDICT_SHORT;
        end else if ((nib_upd < MIN_OFFSET) || ({11'd0, hdr_bytes} > count_upd)) begin
            result.verdict = VERDICT_BAD_HLEN;
        end else if (flags_bad) begin
            result.verdict = VERDICT_BAD_FLAGS;
        end else if (csum_fold == CSUM_GOOD) begin
            result.verdict = VERDICT_ACCEPT;
        end else begin
            result.verdict = VERDICT_BAD_CSUM;
        end
        result.header_bytes  = hdr_bytes;
        result.flag_byte     = flag_upd;
        result.segment_bytes = count_upd[16] ? LEN_SAT : count_upd[15:0];
    end

    always_comb begin
        count_next = count_reg;
        sum_next   = sum_reg;
        high_next  = high_reg;
        odd_next   = odd_reg;
        nib_next   = nib_reg;
        flag_next  = flag_reg;
        if (fire_last) begin
            count_next = '0;
            sum_next   = '0;
            high_next  = '0;
            odd_next   = 1'b0;
            nib_next   = '0;
            flag_next  = '0;
        end else if (fire) begin
            count_next = count_upd;
            sum_next   = sum_upd;
            high_next  = odd_reg ? high_reg : st_data.seg_byte;
            odd_next   = !odd_reg;
            nib_next   = nib_upd;
            flag_next  = flag_upd;
        end
    end

    always_comb begin
        if (fire_last) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            sum_reg     <= '0;
            high_reg    <= '0;
            odd_reg     <= 1'b0;
            nib_reg     <= '0;
            flag_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            count_reg   <= count_next;
            sum_reg     <= sum_next;
            high_reg    <= high_next;
            odd_reg     <= odd_next;
            nib_reg     <= nib_next;
            flag_reg    <= flag_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire_last) begin
            m_data_reg <= result;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

// ----- rtl/tcp_segment_validator_core.sv -----
// TCP segment validator: byte-serial checksum and header sanity check.
// Path: the last byte is held in the input register after its accepting edge; its
// verdict then enters the result register, raising m_valid; an unread verdict can stall it.
// Throughput: one byte per cycle while m_ready keeps up; a verdict left waiting
// stalls the byte stream once the input register holds a byte.
// Reset (aresetn low, synchronous) clears the segment state and both valids.
module tcp_segment_validator_core (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  tsv_pkg::tsv_in_t  s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output tsv_pkg::tsv_out_t m_data
);
    import tsv_pkg::*;

    logic       acc_ready;
    logic       st_valid;
    tsv_stage_t st_data;

    tsv_in_stage u_in_stage (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .acc_ready (acc_ready),
        .st_valid  (st_valid),
        .st_data   (st_data)
    );

    tsv_accum u_accum (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .st_valid  (st_valid),
        .st_data   (st_data),
        .acc_ready (acc_ready),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule
